// ----- rtl/core/npic_pkg.sv -----
// shared types, constants and functions of the nested priority interrupt controller
package npic_pkg;

	localparam int NUM_LINES = 16;
	localparam int LW = 4;
	localparam int CW = 5;

	typedef enum logic [3:0] {
		CMD_INIT     = 4'd0,
		CMD_RAISE    = 4'd1,
		CMD_RAISE_EX = 4'd2,
		CMD_CLEAR    = 4'd3,
		CMD_DISABLE  = 4'd4,
		CMD_ENABLE   = 4'd5,
		CMD_PROBE    = 4'd6,
		CMD_SETMASK  = 4'd7,
		CMD_GETMASK  = 4'd8,
		CMD_SCHEDULE = 4'd9,
		CMD_RETURN   = 4'd10
	} cmd_t;

	typedef enum logic [1:0] {
		ST_INACTIVE = 2'd0,
		ST_PENDING  = 2'd1,
		ST_ACTIVE   = 2'd2,
		ST_ACTPEND  = 2'd3
	} lstat_t;

	typedef enum logic [1:0] {
		KIND_NEW    = 2'd0,
		KIND_ACTIVE = 2'd1,
		KIND_TASK   = 2'd2,
		KIND_IDLE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'd0,
		FSM_EXEC = 2'd1,
		FSM_QUEUE = 2'd2,
		FSM_OUT  = 2'd3
	} fsm_t;

	localparam logic [1:0] REG_URGENCY = 2'd0;
	localparam logic [1:0] REG_ENABLE  = 2'd1;

	// command and status between the controller and the datapath
	typedef struct packed {
		logic load;   // capture input transfer
		logic exec;   // decode and update line state
		logic queue;  // apply one queue shift
	} npic_cmd_t;

	typedef struct packed {
		logic need_queue;
	} npic_stat_t;

	typedef struct packed {
		logic        error;
		logic        flag;
		logic [3:0]  value;
		logic [1:0]  thread_kind;
	} npic_res_t;

	function automatic logic [3:0] urg_of(input logic [63:0] tbl, input logic [3:0] line);
		urg_of = tbl[{line, 2'b00} +: 4];
	endfunction

endpackage

// ----- rtl/core/npic_ctrl.sv -----
// controller state machine: load, execute, queue update, deliver
module npic_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  npic_pkg::npic_stat_t stat,
	output npic_pkg::npic_cmd_t  cmd
);
	import npic_pkg::*;

	fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				cmd.exec = 1'b1;
				state_d = FSM_QUEUE;
			end
			FSM_QUEUE: begin
				if (stat.need_queue) cmd.queue = 1'b1;
				state_d = FSM_OUT;
			end
			FSM_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

endmodule

// ----- rtl/core/npic_dp.sv -----
// datapath: line status, disable flags, saved masks, pending queue, active stack
module npic_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  npic_pkg::npic_cmd_t  cmd,
	output npic_pkg::npic_stat_t stat,
	input  logic [12:0]          in_data,
	input  logic [63:0]          urgency_table,
	input  logic [15:0]          enabled_at_init,
	output npic_pkg::npic_res_t  res
);
	import npic_pkg::*;

	logic [3:0] cmd_q, line_q, mlev_q;
	logic       task_q;
	lstat_t     lstat_q [NUM_LINES];
	logic [NUM_LINES-1:0] dis_q;
	logic [3:0] smask_q [NUM_LINES];
	logic [3:0] pend_q  [NUM_LINES];
	logic [CW-1:0] pcnt_q;
	logic [3:0] act_q   [NUM_LINES];
	logic [CW-1:0] acnt_q;
	logic [3:0] mask_q;
	npic_res_t  res_q;
	// queue operation latched in the execute step
	logic       q_ins_q, q_rem_q, a_rem_q;
	logic [3:0] q_line_q;

	logic       valid_line;
	lstat_t     ls;
	logic [3:0] lu, hu, head;

	assign valid_line = ({1'b0, line_q} < CW'(NUM_LINES));
	assign ls   = lstat_q[line_q[LW-1:0]];
	assign lu   = urg_of(urgency_table, line_q);
	assign head = pend_q[0];
	assign hu   = urg_of(urgency_table, head);
	assign res  = res_q;
	assign stat.need_queue = q_ins_q | q_rem_q | a_rem_q;

	// position of first queued entry less urgent than the inserted line, and match flags
	logic [NUM_LINES-1:0] less, hit_p, hit_a, lowp, lowa;
	logic [3:0] qu;
	always_comb begin
		qu = urg_of(urgency_table, q_line_q);
		for (int i = 0; i < NUM_LINES; i++) begin
			lowp[i]  = (CW'(i) < pcnt_q);
			lowa[i]  = (CW'(i) < acnt_q);
			less[i]  = lowp[i] && (urg_of(urgency_table, pend_q[i]) < qu);
			hit_p[i] = lowp[i] && (pend_q[i] == q_line_q);
			hit_a[i] = lowa[i] && (act_q[i] == q_line_q);
		end
	end
	// prefix flags: at or after the first match
	logic [NUM_LINES-1:0] after_less, after_p, after_a;
	always_comb begin
		after_less[0] = less[0];
		after_p[0] = hit_p[0];
		after_a[0] = hit_a[0];
		for (int i = 1; i < NUM_LINES; i++) begin
			after_less[i] = after_less[i-1] | less[i];
			after_p[i] = after_p[i-1] | hit_p[i];
			after_a[i] = after_a[i-1] | hit_a[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= in_data[3:0];
			line_q <= in_data[7:4];
			mlev_q <= in_data[11:8];
			task_q <= in_data[12];
		end
		if (cmd.exec && cmd_q == CMD_SCHEDULE && pcnt_q != '0 && hu > mask_q)
			smask_q[head] <= mask_q;
		if (cmd.exec && cmd_q == CMD_SCHEDULE && pcnt_q != '0 && hu > mask_q
			&& acnt_q < CW'(NUM_LINES))
			act_q[acnt_q[LW-1:0]] <= head;
		if (cmd.queue && q_ins_q && pcnt_q < CW'(NUM_LINES)) begin
			for (int i = 0; i < NUM_LINES; i++) begin
				if (CW'(i) <= pcnt_q) begin
					if (i > 0 && after_less[i-1]) pend_q[i] <= pend_q[i-1];
					else if (less[i] || CW'(i) == pcnt_q) pend_q[i] <= q_line_q;
				end
			end
		end
		if (cmd.queue && q_rem_q) begin
			for (int i = 0; i < NUM_LINES-1; i++)
				if (after_p[i]) pend_q[i] <= pend_q[i+1];
		end
		if (cmd.queue && a_rem_q) begin
			for (int i = 0; i < NUM_LINES-1; i++)
				if (after_a[i]) act_q[i] <= act_q[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LINES; i++) lstat_q[i] <= ST_INACTIVE;
			dis_q  <= '1;
			pcnt_q <= '0;
			acnt_q <= '0;
			mask_q <= '0;
			q_ins_q <= 1'b0;
			q_rem_q <= 1'b0;
			a_rem_q <= 1'b0;
			q_line_q <= '0;
			res_q  <= '0;
		end else if (cmd.exec) begin
			res_q   <= '0;
			q_ins_q <= 1'b0;
			q_rem_q <= 1'b0;
			a_rem_q <= 1'b0;
			q_line_q <= line_q;
			case (cmd_q)
				CMD_INIT: begin
					for (int i = 0; i < NUM_LINES; i++) lstat_q[i] <= ST_INACTIVE;
					dis_q  <= ~enabled_at_init[NUM_LINES-1:0];
					pcnt_q <= '0;
					acnt_q <= '0;
					mask_q <= '0;
				end
				CMD_RAISE, CMD_RAISE_EX: if (valid_line) begin
					if (ls == ST_INACTIVE) begin
						lstat_q[line_q] <= ST_PENDING;
						if (!dis_q[line_q]) begin
							q_ins_q <= 1'b1;
							if (cmd_q == CMD_RAISE_EX && lu > mask_q) res_q.flag <= 1'b1;
						end
					end else if (ls == ST_ACTIVE) begin
						lstat_q[line_q] <= ST_ACTPEND;
					end
				end
				CMD_CLEAR: if (valid_line) begin
					if (ls == ST_PENDING) begin
						lstat_q[line_q] <= ST_INACTIVE;
						if (!dis_q[line_q]) q_rem_q <= 1'b1;
					end else if (ls == ST_ACTPEND) begin
						lstat_q[line_q] <= ST_ACTIVE;
					end
				end
				CMD_DISABLE: if (valid_line && !dis_q[line_q]) begin
					dis_q[line_q] <= 1'b1;
					if (ls == ST_PENDING) q_rem_q <= 1'b1;
				end
				CMD_ENABLE: if (valid_line && dis_q[line_q]) begin
					dis_q[line_q] <= 1'b0;
					if (ls == ST_PENDING) q_ins_q <= 1'b1;
				end
				CMD_PROBE: begin
					res_q.flag <= valid_line && (ls == ST_PENDING || ls == ST_ACTPEND);
				end
				CMD_SETMASK: mask_q <= mlev_q;
				CMD_GETMASK: res_q.value <= mask_q;
				CMD_SCHEDULE: begin
					if (pcnt_q != '0 && hu > mask_q) begin
						q_rem_q  <= 1'b1;
						q_line_q <= head;
						lstat_q[head] <= ST_ACTIVE;
						if (acnt_q < CW'(NUM_LINES)) acnt_q <= acnt_q + CW'(1);
						mask_q <= hu;
						res_q.value <= head;
						res_q.thread_kind <= KIND_NEW;
					end else if (acnt_q != '0) begin
						res_q.value <= act_q[acnt_q[LW-1:0] - LW'(1)];
						res_q.thread_kind <= KIND_ACTIVE;
					end else begin
						res_q.thread_kind <= task_q ? KIND_TASK : KIND_IDLE;
					end
				end
				CMD_RETURN: begin
					if (!valid_line || (ls != ST_ACTIVE && ls != ST_ACTPEND)) begin
						res_q.error <= 1'b1;
					end else begin
						a_rem_q <= 1'b1;
						if (ls == ST_ACTIVE) begin
							lstat_q[line_q] <= ST_INACTIVE;
						end else begin
							lstat_q[line_q] <= ST_PENDING;
							if (!dis_q[line_q]) q_ins_q <= 1'b1;
						end
						mask_q <= smask_q[line_q];
					end
				end
				default: ;
			endcase
		end else if (cmd.queue) begin
			// removal of a pending entry, then insertion are exclusive per command
			if (q_rem_q && after_p[NUM_LINES-1]) pcnt_q <= pcnt_q - CW'(1);
			if (q_ins_q && pcnt_q < CW'(NUM_LINES)) pcnt_q <= pcnt_q + CW'(1);
			if (a_rem_q && after_a[NUM_LINES-1]) acnt_q <= acnt_q - CW'(1);
		end
	end

endmodule

// ----- rtl/core/nested_priority_interrupt_controller_core.sv -----
// top level of the nested priority interrupt controller
//
// channel   dir  tdata fields (low bit first)                  tuser
// s_axis    in   command[3:0] line_number[7:4] mask_level[11:8]  -
//                task_present[12] (zero-filled to 16 bits)
// m_axis    out  error[0] flag[1] value[5:2] thread_kind[7:6]  -
// apb       cfg  0x00 urgency_table (64b), 0x08 enabled_at_init
//
// every command passes in order through capture, execute, queue shift and deliver
// the pending queue and active stack shift all entries in one step of the shift
// network, so no command loops; the result register holds until taken
// reset clears line state, disables every line and zeroes mask and counts;
// saved masks are written before they are read, so need no reset
// a stalled result holds the controller in its deliver state
module nested_priority_interrupt_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // command, line_number, mask_level, task_present
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // error, flag, value, thread_kind
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import npic_pkg::*;

	logic [63:0] urg_q;
	logic [15:0] en_q;
	npic_cmd_t  cmd;
	npic_stat_t stat;
	npic_res_t  res;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3] ? REG_ENABLE : REG_URGENCY;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			urg_q <= '0;
			en_q  <= '0;
		end else if (psel && penable && pwrite && !paddr[2] && !paddr[1] && !paddr[0]) begin
			if (reg_idx == REG_URGENCY) urg_q <= pwdata;
			else en_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (!paddr[2]) prdata = (reg_idx == REG_URGENCY) ? urg_q : {48'd0, en_q};
	end

	npic_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	npic_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_data         (s_axis_tdata[12:0]),
		.urgency_table   (urg_q),
		.enabled_at_init (en_q),
		.res             (res)
	);

	assign m_axis_tdata = {res.thread_kind, res.value, res.flag, res.error};

endmodule

// ----- rtl/core/npic_checker.sv -----
// port-level checks of the interrupt controller, bound to the top level
module npic_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata
);
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("ready while result held");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> ##2 m_axis_tvalid) else $error("result late");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_error_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[7:1] == 7'd0)
		else $error("error with other fields");
endmodule

bind nested_priority_interrupt_controller_core npic_checker u_npic_checker (
	.clk (clk), .arst_n (arst_n), .s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready), .m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready), .m_axis_tdata (m_axis_tdata)
);
